### src/psq_pkg.sv
// shared types, constants and helpers of the polyline stroke quad unit
`timescale 1ns / 1ps

package psq_pkg;

    // field widths
    localparam int PT_W       = 16;   // point and vertex coordinate, signed Q12.4
    localparam int W_W        = 12;   // stroke width, unsigned Q8.4
    localparam int COL_W      = 32;   // rgba color
    localparam int EI_OUT_W   = 16;   // edge index field on the output
    localparam int EDGE_INDEX_BITS = 16;  // width of the running edge counter

    // offset datapath widths
    localparam int MAG_W  = 16;       // |dx|, |dy|
    localparam int PROD_W = 32;       // 16 x 16 product
    localparam int SQ_W   = 33;       // dx*dx + dy*dy
    localparam int NUM_W  = 28;       // |d| * width
    localparam int ROOT_W = 25;       // length in 1/256 units
    localparam int RAD_W  = 50;       // radicand, squared length shifted by 16
    localparam int REM_W  = 27;       // square root partial remainder
    localparam int Q_W    = 12;       // offset magnitude
    localparam int OFF_W  = 13;       // signed offset
    localparam int CS_W   = 37;       // shared compare-subtract width
    localparam int CNT_W  = 5;        // iteration counter

    // stream and configuration widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STROKE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED_PATH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STROKE_COLOR = 2'd2;

    // register reset values
    localparam logic [W_W-1:0]   RST_STROKE_WIDTH = 12'd16;
    localparam logic             RST_CLOSED_PATH  = 1'b0;
    localparam logic [COL_W-1:0] RST_STROKE_COLOR = 32'hFFFF_FFFF;

    // quad corner codes
    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;
    localparam logic [1:0] CORNER_3 = 2'd3;

    // edge request from the point control to the offset engine
    typedef struct packed {
        logic signed [PT_W-1:0] x1;
        logic signed [PT_W-1:0] y1;
        logic signed [PT_W-1:0] x2;
        logic signed [PT_W-1:0] y2;
        logic [W_W-1:0]         width;
    } t_edge_req;

    // offset engine result, valid on the done beat and held afterwards
    typedef struct packed {
        logic                    done;
        logic signed [OFF_W-1:0] ox;
        logic signed [OFF_W-1:0] oy;
    } t_edge_rsp;

    // clamp a 17-bit sum to the 16-bit coordinate range
    function automatic logic signed [PT_W-1:0] sat16(input logic signed [PT_W:0] v);
        logic signed [PT_W-1:0] res;
        if (v[PT_W] != v[PT_W-1]) begin
            res = v[PT_W] ? {1'b1, {(PT_W-1){1'b0}}} : {1'b0, {(PT_W-1){1'b1}}};
        end else begin
            res = v[PT_W-1:0];
        end
        return res;
    endfunction

endpackage

### src/psq_cmpsub.sv
// shared compare-subtract unit used by the square root and the divider
`timescale 1ns / 1ps

module psq_cmpsub (
    input  logic [psq_pkg::CS_W-1:0] i_a,
    input  logic [psq_pkg::CS_W-1:0] i_b,
    output logic                     o_ge,
    output logic [psq_pkg::CS_W-1:0] o_diff
);

    logic [psq_pkg::CS_W:0] w_sub;

    // one wide subtract, borrow gives the compare
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[psq_pkg::CS_W];
    assign o_diff = w_sub[psq_pkg::CS_W-1:0];

endmodule

### src/psq_edge.sv
// per-edge offset engine: squares, digit-by-digit square root, restoring divide
`timescale 1ns / 1ps

module psq_edge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  psq_pkg::t_edge_req i_req,
    output psq_pkg::t_edge_rsp o_rsp
);

    typedef enum logic [2:0] {
        E_IDLE,
        E_MUL,
        E_SQRT,
        E_PREP,
        E_DIV,
        E_DONE
    } t_estate;

    t_estate r_state;

    logic [psq_pkg::MAG_W-1:0]  r_ax, r_ay;
    logic                       r_sx, r_sy;
    logic [psq_pkg::W_W-1:0]    r_w;
    logic [1:0]                 r_mstep;
    logic [psq_pkg::SQ_W-1:0]   r_acc;
    logic [psq_pkg::NUM_W-1:0]  r_numx, r_numy;
    logic [psq_pkg::RAD_W-1:0]  r_rad;
    logic [psq_pkg::REM_W-1:0]  r_rem;
    logic [psq_pkg::ROOT_W-1:0] r_root;
    logic [psq_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_sel;
    logic [psq_pkg::CS_W-1:0]   r_num, r_dsh;
    logic [psq_pkg::Q_W-1:0]    r_q;
    logic signed [psq_pkg::OFF_W-1:0] r_ox, r_oy;
    logic                       r_done;

    logic signed [psq_pkg::PT_W:0]   n_dx, n_dy;
    logic [psq_pkg::MAG_W-1:0]       n_ax, n_ay;
    logic [psq_pkg::MAG_W-1:0]       w_mul_a, w_mul_b;
    logic [psq_pkg::PROD_W-1:0]      w_prod;
    logic [psq_pkg::REM_W+1:0]       w_rem_sh, w_trial;
    logic [psq_pkg::CS_W-1:0]        w_cs_a, w_cs_b, w_cs_diff;
    logic                            w_cs_ge;
    logic [psq_pkg::Q_W-1:0]         n_q;
    logic signed [psq_pkg::OFF_W-1:0] n_off;
    logic [psq_pkg::NUM_W-1:0]       w_num_sel;

    // edge vector and magnitudes at start
    assign n_dx = {i_req.x2[psq_pkg::PT_W-1], i_req.x2} - {i_req.x1[psq_pkg::PT_W-1], i_req.x1};
    assign n_dy = {i_req.y2[psq_pkg::PT_W-1], i_req.y2} - {i_req.y1[psq_pkg::PT_W-1], i_req.y1};
    assign n_ax = n_dx[psq_pkg::PT_W] ? psq_pkg::MAG_W'(-n_dx) : n_dx[psq_pkg::MAG_W-1:0];
    assign n_ay = n_dy[psq_pkg::PT_W] ? psq_pkg::MAG_W'(-n_dy) : n_dy[psq_pkg::MAG_W-1:0];

    // shared multiplier: ax*ax, ay*ay, ax*w, ay*w
    assign w_mul_a = r_mstep[0] ? r_ay : r_ax;
    assign w_mul_b = r_mstep[1] ? psq_pkg::MAG_W'(r_w) : w_mul_a;
    assign w_prod  = w_mul_a * w_mul_b;

    // square root step operands
    assign w_rem_sh = {r_rem, r_rad[psq_pkg::RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};

    // compare-subtract operand select
    always_comb begin
        if (r_state == E_SQRT) begin
            w_cs_a = psq_pkg::CS_W'(w_rem_sh);
            w_cs_b = psq_pkg::CS_W'(w_trial);
        end else begin
            w_cs_a = r_num;
            w_cs_b = r_dsh;
        end
    end

    psq_cmpsub u_cmpsub (
        .i_a    (w_cs_a),
        .i_b    (w_cs_b),
        .o_ge   (w_cs_ge),
        .o_diff (w_cs_diff)
    );

    // quotient, signed offset and numerator select
    assign n_q       = {r_q[psq_pkg::Q_W-2:0], w_cs_ge};
    assign n_off     = (r_sel ? r_sy : r_sx) ? -psq_pkg::OFF_W'({1'b0, n_q})
                                             :  psq_pkg::OFF_W'({1'b0, n_q});
    assign w_num_sel = r_sel ? r_numy : r_numx;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_ax    <= n_ax;
                        r_ay    <= n_ay;
                        r_sx    <= n_dx[psq_pkg::PT_W];
                        r_sy    <= n_dy[psq_pkg::PT_W];
                        r_w     <= i_req.width;
                        r_mstep <= 2'd0;
                        r_state <= E_MUL;
                    end
                end
                E_MUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    unique case (r_mstep)
                        2'd0: r_acc  <= psq_pkg::SQ_W'(w_prod);
                        2'd1: r_acc  <= r_acc + psq_pkg::SQ_W'(w_prod);
                        2'd2: r_numx <= psq_pkg::NUM_W'(w_prod);
                        2'd3: begin
                            r_numy <= psq_pkg::NUM_W'(w_prod);
                            if (r_acc == '0) begin
                                // zero-length edge gets no offset
                                r_ox    <= '0;
                                r_oy    <= '0;
                                r_state <= E_DONE;
                            end else begin
                                r_rad   <= {1'b0, r_acc, 16'd0};
                                r_rem   <= '0;
                                r_root  <= '0;
                                r_cnt   <= psq_pkg::CNT_W'(psq_pkg::ROOT_W - 1);
                                r_state <= E_SQRT;
                            end
                        end
                        default: r_state <= E_IDLE;
                    endcase
                end
                E_SQRT: begin
                    r_rad <= {r_rad[psq_pkg::RAD_W-3:0], 2'b00};
                    if (w_cs_ge) begin
                        r_rem  <= w_cs_diff[psq_pkg::REM_W-1:0];
                        r_root <= {r_root[psq_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh[psq_pkg::REM_W-1:0];
                        r_root <= {r_root[psq_pkg::ROOT_W-2:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_sel   <= 1'b0;
                        r_state <= E_PREP;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                E_PREP: begin
                    // numerator |d|*w*256 + L8 for rounding, divisor 2*L8 aligned up
                    r_num   <= psq_pkg::CS_W'({w_num_sel, 8'd0}) + psq_pkg::CS_W'(r_root);
                    r_dsh   <= {r_root, {psq_pkg::Q_W{1'b0}}};
                    r_q     <= '0;
                    r_cnt   <= psq_pkg::CNT_W'(psq_pkg::Q_W - 1);
                    r_state <= E_DIV;
                end
                E_DIV: begin
                    if (w_cs_ge) begin
                        r_num <= w_cs_diff;
                    end
                    r_q   <= n_q;
                    r_dsh <= r_dsh >> 1;
                    if (r_cnt == '0) begin
                        if (!r_sel) begin
                            r_ox    <= n_off;
                            r_sel   <= 1'b1;
                            r_state <= E_PREP;
                        end else begin
                            r_oy    <= n_off;
                            r_state <= E_DONE;
                        end
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                E_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ox   = r_ox;
    assign o_rsp.oy   = r_oy;

    // offsets never exceed half the widest stroke
    a_off_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_ox <= 13'sd2048) && (r_ox >= -13'sd2048)
                && (r_oy <= 13'sd2048) && (r_oy >= -13'sd2048))
        else $error("offset out of range");

    // restoring divide keeps the remainder below twice the shifted divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_DIV) |-> ({1'b0, r_num} < {r_dsh, 1'b0}))
        else $error("divide remainder too large");

endmodule

### src/polyline_stroke_quads_unit.sv
// top level: point stream in, stroke quad corner vertices out
`timescale 1ns / 1ps

// Takes polyline points (signed Q12.4) one beat at a time and emits, for each
// edge, the four corners of a quad offset by half the stroke width along the
// edge normal, in corner order 0..3 (triangles 0,1,2 and 0,2,3). The first
// point of a polyline emits nothing; a point with tlast ends the polyline and,
// with closed_path set, also emits the closing edge back to the first point.
// tlast on the output marks the last vertex caused by an input beat. Every
// edge runs through one shared multiplier and one compare-subtract unit,
// 4 multiply steps, 25 square-root steps and two 12-step divides, then 4
// output beats, which wait while the output stalls. The input is not ready
// while an edge is in flight.
// Configuration writes are accepted at any time and should be made while idle.

module polyline_stroke_quads_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // point input; tdata: point_x[15:0], point_y[31:16]; tlast: last_point
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [psq_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic                                i_s_tlast,
    // vertex output; tdata: vertex_x[15:0], vertex_y[31:16], vertex_color[63:32],
    // corner[65:64], edge_index[81:66], zero[87:82]; tlast: last_of_run
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [psq_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int EIB = psq_pkg::EDGE_INDEX_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } t_state;

    t_state r_state;

    logic [psq_pkg::W_W-1:0]          r_width;
    logic                             r_closed;
    logic [psq_pkg::COL_W-1:0]        r_color;
    logic signed [psq_pkg::PT_W-1:0]  r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                             r_have_pt;
    logic [EIB-1:0]                   r_edge_cnt;
    logic signed [psq_pkg::PT_W-1:0]  r_ex1, r_ey1, r_ex2, r_ey2;
    logic                             r_close_pend;
    logic [1:0]                       r_corner;
    logic                             r_m_valid;
    logic signed [psq_pkg::PT_W-1:0]  r_vx, r_vy;
    logic [psq_pkg::COL_W-1:0]        r_vcolor;
    logic [1:0]                       r_vcorner;
    logic [psq_pkg::EI_OUT_W-1:0]     r_vedge;
    logic                             r_vlast;

    psq_pkg::t_edge_req               w_req;
    psq_pkg::t_edge_rsp               w_rsp;
    logic                             w_in_acc, w_load, w_first_end;
    logic signed [psq_pkg::PT_W-1:0]  w_in_x, w_in_y, w_px, w_py;
    logic signed [psq_pkg::PT_W:0]    w_offx, w_offy, w_ox, w_oy, w_sx, w_sy;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_in_x      = i_s_tdata[15:0];
    assign w_in_y      = i_s_tdata[31:16];
    assign w_load      = (r_state == ST_EMIT) && (!r_m_valid || i_m_tready);

    // offset engine
    assign w_req.x1    = r_ex1;
    assign w_req.y1    = r_ey1;
    assign w_req.x2    = r_ex2;
    assign w_req.y2    = r_ey2;
    assign w_req.width = r_width;

    psq_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // corner position: start point for corners 0 and 3, end point for 1 and 2
    assign w_first_end = (r_corner == psq_pkg::CORNER_0) || (r_corner == psq_pkg::CORNER_3);
    assign w_px = w_first_end ? r_ex1 : r_ex2;
    assign w_py = w_first_end ? r_ey1 : r_ey2;
    assign w_ox = {{(psq_pkg::PT_W + 1 - psq_pkg::OFF_W){w_rsp.ox[psq_pkg::OFF_W-1]}}, w_rsp.ox};
    assign w_oy = {{(psq_pkg::PT_W + 1 - psq_pkg::OFF_W){w_rsp.oy[psq_pkg::OFF_W-1]}}, w_rsp.oy};

    // left side (+oy, -ox) for corners 0 and 1, right side for 2 and 3
    always_comb begin
        if ((r_corner == psq_pkg::CORNER_0) || (r_corner == psq_pkg::CORNER_1)) begin
            w_offx = w_oy;
            w_offy = -w_ox;
        end else begin
            w_offx = -w_oy;
            w_offy = w_ox;
        end
    end

    assign w_sx = {w_px[psq_pkg::PT_W-1], w_px} + w_offx;
    assign w_sy = {w_py[psq_pkg::PT_W-1], w_py} + w_offy;

    // control, point state, registers and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_width      <= psq_pkg::RST_STROKE_WIDTH;
            r_closed     <= psq_pkg::RST_CLOSED_PATH;
            r_color      <= psq_pkg::RST_STROKE_COLOR;
            r_first_x    <= '0;
            r_first_y    <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_have_pt    <= 1'b0;
            r_edge_cnt   <= '0;
            r_close_pend <= 1'b0;
            r_corner     <= psq_pkg::CORNER_0;
            r_m_valid    <= 1'b0;
        end else begin
            // register writes, unknown index ignored
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    psq_pkg::REG_STROKE_WIDTH: r_width  <= i_cfg_data[psq_pkg::W_W-1:0];
                    psq_pkg::REG_CLOSED_PATH:  r_closed <= i_cfg_data[0];
                    psq_pkg::REG_STROKE_COLOR: r_color  <= i_cfg_data;
                    default: ;
                endcase
            end

            // output register
            if (w_load) begin
                r_m_valid <= 1'b1;
                r_vx      <= psq_pkg::sat16(w_sx);
                r_vy      <= psq_pkg::sat16(w_sy);
                r_vcolor  <= r_color;
                r_vcorner <= r_corner;
                r_vedge   <= psq_pkg::EI_OUT_W'(r_edge_cnt);
                r_vlast   <= (r_corner == psq_pkg::CORNER_3) && !r_close_pend;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_prev_x <= w_in_x;
                        r_prev_y <= w_in_y;
                        if (!r_have_pt) begin
                            // first point of a polyline
                            r_first_x <= w_in_x;
                            r_first_y <= w_in_y;
                            r_have_pt <= !i_s_tlast;
                        end else begin
                            r_ex1        <= r_prev_x;
                            r_ey1        <= r_prev_y;
                            r_ex2        <= w_in_x;
                            r_ey2        <= w_in_y;
                            r_close_pend <= i_s_tlast && r_closed;
                            r_have_pt    <= !i_s_tlast;
                            r_state      <= ST_START;
                        end
                    end
                end
                ST_START: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_rsp.done) begin
                        r_corner <= psq_pkg::CORNER_0;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_corner <= r_corner + 2'd1;
                        if (r_corner == psq_pkg::CORNER_3) begin
                            r_edge_cnt <= r_edge_cnt + EIB'(1);
                            if (r_close_pend) begin
                                // closing edge from the last point back to the first
                                r_close_pend <= 1'b0;
                                r_ex1        <= r_ex2;
                                r_ey1        <= r_ey2;
                                r_ex2        <= r_first_x;
                                r_ey2        <= r_first_y;
                                r_state      <= ST_START;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tlast  = r_vlast;
    assign o_m_tdata  = {6'd0, r_vedge, r_vcorner, r_vcolor, r_vy, r_vx};

    // the engine only finishes while an edge is being waited on
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_WAIT))
        else $error("edge result outside wait state");

    // end of run only ever falls on the fourth corner
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (r_vcorner == psq_pkg::CORNER_3))
        else $error("tlast on a corner other than the last");

    // edge counter steps once per finished quad
    a_edge_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_corner == psq_pkg::CORNER_3))
            |=> (r_edge_cnt == $past(r_edge_cnt) + EIB'(1)))
        else $error("edge counter did not advance");

endmodule
